FILE: rtl/core/brd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brd_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);
  localparam int STEP_W = 18;
  localparam int ROWPOS_W = 34;
  localparam int SLOT_W = 3;
  localparam int NSLOT = 6;

  localparam logic [2:0] REG_INV_STEP   = 3'd0;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd1;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd2;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd4;

  typedef struct packed {
    logic              busy;
    logic              accept;
    logic              eval;
    logic              mul;
    logic              load;
    logic [SLOT_W-1:0] slot;
  } brd_cmd_t;

  typedef struct packed {
    logic slot_on;
    logic more_after;
    logic out_ready;
  } brd_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/brd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module brd_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  brd_pkg::brd_status_t status_i,
  output brd_pkg::brd_cmd_t    cmd_o
);
  import brd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  always_comb begin
    state_d = state_q;
    slot_d = slot_q;
    cmd_o = '0;
    cmd_o.busy = (state_q != S_IDLE);
    cmd_o.slot = slot_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        slot_d = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (status_i.slot_on) begin
          cmd_o.mul = 1'b1;
          state_d = S_OUT;
        end else if (status_i.more_after) begin
          slot_d = slot_q + SLOT_W'(1);
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (status_i.out_ready) begin
          cmd_o.load = 1'b1;
          if (status_i.more_after) begin
            slot_d = slot_q + SLOT_W'(1);
            state_d = S_MUL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q <= '0;
    end else begin
      state_q <= state_d;
      slot_q <= slot_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_EVAL) else $error("accept not followed by eval");
  a_load_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_OUT) else $error("load outside output state");
  a_eval_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |=> state_q == S_MUL && slot_q == '0) else $error("bad slot start");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |-> slot_q < SLOT_W'(NSLOT)) else $error("slot out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/brd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module brd_dpath #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  brd_pkg::brd_cmd_t    cmd_i,
  output brd_pkg::brd_status_t status_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [4:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  input  wire  [7:0]           comp_a_i,
  input  wire  [7:0]           comp_b_i,
  input  wire  [7:0]           comp_c_i,
  input  wire                  out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           out_a_o,
  output logic [7:0]           out_b_o,
  output logic [7:0]           out_c_o,
  output logic [11:0]          dst_x_o,
  output logic [15:0]          dst_y_o,
  output logic                 run_last_o,
  output logic                 frame_end_o
);
  import brd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int PW = CW + 19;

  // configuration
  logic [17:0] inv_step_q;
  logic [12:0] src_width_q, dst_width_q;
  logic [15:0] src_height_q, dst_height_q;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_q <= 18'd131072;
      src_width_q <= 13'd640;
      src_height_q <= 16'd480;
      dst_width_q <= 13'd320;
      dst_height_q <= 16'd240;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_INV_STEP:   inv_step_q <= pwdata[17:0];
        REG_SRC_WIDTH:  src_width_q <= pwdata[12:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[15:0];
        REG_DST_WIDTH:  dst_width_q <= pwdata[12:0];
        REG_DST_HEIGHT: dst_height_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INV_STEP:   prdata = 32'(inv_step_q);
      REG_SRC_WIDTH:  prdata = 32'(src_width_q);
      REG_SRC_HEIGHT: prdata = 32'(src_height_q);
      REG_DST_WIDTH:  prdata = 32'(dst_width_q);
      REG_DST_HEIGHT: prdata = 32'(dst_height_q);
      default:        prdata = '0;
    endcase
  end

  // clamped settings
  logic [17:0] step;
  logic [XW-1:0] sw, wc, wm1;
  logic [15:0] hm1;

  always_comb begin
    if (inv_step_q < 18'(ONE) + 18'd1) step = 18'(ONE) + 18'd1;
    else if (inv_step_q > {ONE, 1'b0}) step = {ONE, 1'b0};
    else step = inv_step_q;
    sw = XW'(src_width_q);
    if (sw == '0) wc = XW'(1);
    else if (sw > XW'(MAX_WIDTH)) wc = XW'(MAX_WIDTH);
    else wc = sw;
    wm1 = wc - XW'(1);
    hm1 = (src_height_q == '0) ? 16'd0 : src_height_q - 16'd1;
  end

  // stream state
  logic [CW-1:0]       src_col_q;
  logic [15:0]         src_row_q, dst_row_q;
  logic [12:0]         dst_col_q;
  logic [PW-1:0]       colpos_q;
  logic [ROWPOS_W-1:0] rowpos_q;
  logic [23:0]         left_cur_q, left_above_q;
  logic [23:0]         pix_q, above_q;
  logic [23:0]         row_store [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= {comp_c_i, comp_b_i, comp_a_i};
      above_q <= row_store[src_col_q];
    end
    if (cmd_i.eval) row_store[src_col_q] <= pix_q;
  end

  // evaluation
  logic                last_col, last_row, c0_on, c1_on;
  logic                first_on, mid_on, end_on;
  logic [12:0]         dst_col1, dst_col2;
  logic [PW-1:0]       colpos1, colpos2;
  logic [PW-17:0]      colint, colint1;
  logic [ROWPOS_W-17:0] rowint;
  logic [16:0]         row_lim;

  always_comb begin
    last_col = 32'(src_col_q) >= 32'(wm1);
    last_row = src_row_q >= hm1;
    colint = colpos_q[PW-1:16];
    c0_on = (src_col_q != '0) && (dst_col_q < dst_width_q)
            && (32'(colint) + 32'd1 == 32'(src_col_q));
    dst_col1 = dst_col_q + 13'(c0_on);
    colpos1 = c0_on ? colpos_q + PW'(step) : colpos_q;
    colint1 = colpos1[PW-1:16];
    c1_on = last_col && (dst_col1 < dst_width_q) && (32'(colint1) >= 32'(wm1));
    dst_col2 = dst_col1 + 13'(c1_on);
    colpos2 = c1_on ? colpos1 + PW'(step) : colpos1;
    rowint = rowpos_q[ROWPOS_W-1:16];
    row_lim = {1'b0, dst_row_q} + 17'd2;
    first_on = (src_row_q == '0) && (dst_height_q != '0);
    mid_on = (dst_row_q != '0) && (row_lim <= {1'b0, dst_height_q})
             && (32'(rowint) + 32'd1 == 32'(src_row_q));
    end_on = last_row && (dst_height_q >= 16'd2);
  end

  // captured candidates
  logic [12:0]  x_q [2];
  logic [15:0]  fx_q [2];
  logic [23:0]  ul_q [2], ur_q [2], dl_q [2], dr_q [2];
  logic [15:0]  fy_q, ymid_q;
  logic [NSLOT-1:0] mask_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      x_q[0] <= dst_col_q;
      fx_q[0] <= colpos_q[15:0];
      ul_q[0] <= left_above_q;
      ur_q[0] <= above_q;
      dl_q[0] <= left_cur_q;
      dr_q[0] <= pix_q;
      x_q[1] <= dst_col1;
      fx_q[1] <= colpos1[15:0];
      ul_q[1] <= above_q;
      ur_q[1] <= above_q;
      dl_q[1] <= pix_q;
      dr_q[1] <= pix_q;
      fy_q <= rowpos_q[15:0];
      ymid_q <= dst_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      src_col_q <= '0;
      src_row_q <= '0;
      dst_row_q <= '0;
      dst_col_q <= '0;
      colpos_q <= '0;
      rowpos_q <= '0;
      left_cur_q <= '0;
      left_above_q <= '0;
    end else if (cmd_i.eval) begin
      mask_q <= {end_on && c1_on, end_on && c0_on, mid_on && c1_on, mid_on && c0_on,
                 first_on && c1_on, first_on && c0_on};
      left_cur_q <= pix_q;
      left_above_q <= above_q;
      if (last_col) begin
        src_col_q <= '0;
        dst_col_q <= '0;
        colpos_q <= '0;
        if (last_row) begin
          src_row_q <= '0;
          dst_row_q <= '0;
          rowpos_q <= '0;
        end else begin
          src_row_q <= src_row_q + 16'd1;
          if (mid_on || dst_row_q == '0) begin
            dst_row_q <= dst_row_q + 16'd1;
            rowpos_q <= rowpos_q + ROWPOS_W'(step);
          end
        end
      end else begin
        src_col_q <= src_col_q + CW'(1);
        dst_col_q <= dst_col2;
        colpos_q <= colpos2;
      end
    end
  end

  // slot status
  always_comb begin
    status_o.slot_on = 1'b0;
    status_o.more_after = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (SLOT_W'(i) == cmd_i.slot) status_o.slot_on = mask_q[i];
      if (SLOT_W'(i) > cmd_i.slot && mask_q[i]) status_o.more_after = 1'b1;
    end
    status_o.out_ready = !out_valid_o || !out_stall_i;
  end

  // horizontal blend stage
  logic        q_sel;
  logic [1:0]  t_sel;
  logic [16:0] wl, wr;
  logic [24:0] top_d [3], bot_d [3];
  logic [24:0] top_q [3], bot_q [3];
  logic        mid_q;
  logic [12:0] xs_q;
  logic [15:0] ys_q;

  assign q_sel = cmd_i.slot[0];
  assign t_sel = cmd_i.slot[2:1];

  always_comb begin
    wr = {1'b0, fx_q[q_sel]};
    wl = ONE - wr;
    for (int k = 0; k < 3; k++) begin
      top_d[k] = 25'(ul_q[q_sel][8*k +: 8] * wl) + 25'(ur_q[q_sel][8*k +: 8] * wr);
      bot_d[k] = 25'(dl_q[q_sel][8*k +: 8] * wl) + 25'(dr_q[q_sel][8*k +: 8] * wr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int k = 0; k < 3; k++) begin
        top_q[k] <= top_d[k];
        bot_q[k] <= bot_d[k];
      end
      mid_q <= (t_sel == 2'd1);
      xs_q <= x_q[q_sel];
      case (t_sel)
        2'd0:    ys_q <= '0;
        2'd1:    ys_q <= ymid_q;
        default: ys_q <= dst_height_q - 16'd1;
      endcase
    end
  end

  // vertical blend and output register
  logic [16:0] wb, wt;
  logic [41:0] vsum [3];
  logic [7:0]  res [3];

  always_comb begin
    wb = {1'b0, fy_q};
    wt = ONE - wb;
    for (int k = 0; k < 3; k++) begin
      vsum[k] = 42'(top_q[k] * wt) + 42'(bot_q[k] * wb);
      res[k] = mid_q ? vsum[k][2*FRAC_BITS +: 8] : bot_q[k][FRAC_BITS +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.load) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_a_o <= res[0];
      out_b_o <= res[1];
      out_c_o <= res[2];
      dst_x_o <= xs_q[11:0];
      dst_y_o <= ys_q;
      run_last_o <= !status_o.more_after;
      frame_end_o <= (dst_height_q != '0) && (ys_q == dst_height_q - 16'd1)
                     && (xs_q + 13'd1 == dst_width_q);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bilinear_rgb_downscaler.sv
// Bilinear RGB downscaler.
// Source pixels (comp_a/b/c) enter in raster order on the input channel
// (in_valid_i / in_stall_o); destination pixels leave on the output channel
// (out_valid_o / out_stall_i) with their column, row, a run_last flag on the
// last beat caused by one source pixel and frame_end on the frame's final pixel.
// The user must set sizes and step over the APB port while the block is idle;
// the block itself does not enforce this. A source pixel is taken as the row
// buffer is read, then evaluated; candidate slots are then scanned, a step per
// slot skipped (a single one with no result), and each result beat gets a
// horizontal multiply step, registered, then a vertical one into the output
// register; the sequencer handles one pixel at a time.
// The previous source row is held in a single-port row buffer of MAX_WIDTH
// entries, read when a pixel is taken and written back during evaluation.
// Reset restores the default registers and puts the block at the start of a frame.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits; in_stall_o stays high until the pixel's last beat is loaded.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_rgb_downscaler #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  comp_a_i,
  input  wire  [7:0]  comp_b_i,
  input  wire  [7:0]  comp_c_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  out_a_o,
  output logic [7:0]  out_b_o,
  output logic [7:0]  out_c_o,
  output logic [11:0] dst_x_o,
  output logic [15:0] dst_y_o,
  output logic        run_last_o,
  output logic        frame_end_o
);
  import brd_pkg::*;

  brd_cmd_t    cmd;
  brd_status_t status;

  assign pready = 1'b1;
  assign in_stall_o = cmd.busy;

  brd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  brd_dpath #(.MAX_WIDTH(MAX_WIDTH)) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .comp_a_i   (comp_a_i),
    .comp_b_i   (comp_b_i),
    .comp_c_i   (comp_c_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_a_o    (out_a_o),
    .out_b_o    (out_b_o),
    .out_c_o    (out_c_o),
    .dst_x_o    (dst_x_o),
    .dst_y_o    (dst_y_o),
    .run_last_o (run_last_o),
    .frame_end_o(frame_end_o)
  );

endmodule

`default_nettype wire
